@@ rtl/rmth_pkg.sv @@
// ---------------------------------------------------------------------------
// rmth_pkg
// Shared constants and types for the two-heap running median block.
// ---------------------------------------------------------------------------
package rmth_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOPS,
        S_DECIDE,
        S_POP_LAST,
        S_POP_RD,
        S_POP_CMP,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_DONE
    } t_state;

endpackage

@@ rtl/rmth_ram.sv @@
// ---------------------------------------------------------------------------
// rmth_ram
// Generic single-clock RAM: one write port, two read ports, registered read.
// ---------------------------------------------------------------------------
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/rmth_ctrl.sv @@
// ---------------------------------------------------------------------------
// rmth_ctrl
// Sequencer: placement decision, pop sift-down and push sift-up over the
// two heap memories, one level per cycle.
// ---------------------------------------------------------------------------
module rmth_ctrl
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DEPTH       = CAPACITY / 2 + 1,
    parameter int AW          = $clog2(DEPTH),
    parameter int CW          = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS:0]   o_median_twice,
    output logic [CW-1:0]          o_stored_count,
    output logic                   o_dropped,
    // heap memory ports; index 0 is the lower heap, 1 the upper heap
    output logic [1:0]             o_we,
    output logic [AW-1:0]          o_waddr,
    output logic [SAMPLE_BITS-1:0] o_wdata,
    output logic [AW-1:0]          o_raddr_a,
    output logic [AW-1:0]          o_raddr_b,
    input  logic [SAMPLE_BITS-1:0] i_rdata_a [2],
    input  logic [SAMPLE_BITS-1:0] i_rdata_b [2]
);

    localparam logic [AW:0] ONE = {{AW{1'b0}}, 1'b1};

    t_state r_state, n_state;
    logic [AW:0]  r_size [2];
    logic [AW:0]  n_size [2];
    logic signed [SAMPLE_BITS-1:0] r_v, n_v;    // value being pushed
    logic signed [SAMPLE_BITS-1:0] r_t, n_t;    // popped top, pushed later
    logic signed [SAMPLE_BITS-1:0] r_mv, n_mv;  // value sifting in pop
    logic [AW:0]  r_i, n_i;
    logic         r_ph, n_ph;                   // heap being pushed/popped
    logic         r_second, n_second;           // a second push follows
    logic         r_drop, n_drop;
    logic         r_ov, n_ov;
    logic [SAMPLE_BITS:0] r_med, n_med;

    logic signed [SAMPLE_BITS-1:0] top_l, top_u, ra, rb;
    logic [AW:0] tot;
    logic [AW:0] lc, rc;
    logic signed [SAMPLE_BITS-1:0] best_v;
    logic [AW:0] best_i;

    assign top_l = i_rdata_a[0];
    assign top_u = i_rdata_a[1];
    assign ra    = i_rdata_a[r_ph];
    assign rb    = i_rdata_b[r_ph];

    function automatic logic above(input logic mx, input logic signed [SAMPLE_BITS-1:0] a,
                                   input logic signed [SAMPLE_BITS-1:0] b);
        above = mx ? (a > b) : (a < b);
    endfunction

    assign o_ready        = (r_state == S_IDLE) && !r_ov;
    assign o_valid        = r_ov;
    assign o_median_twice = r_med;
    assign o_dropped      = r_drop;
    assign o_stored_count = CW'({1'b0, r_size[0]} + {1'b0, r_size[1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size[0] <= '0;
            r_size[1] <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size[0] <= n_size[0];
            r_size[1] <= n_size[1];
            r_ov      <= n_ov;
        end
        r_v <= n_v; r_t <= n_t; r_mv <= n_mv; r_i <= n_i; r_ph <= n_ph;
        r_second <= n_second; r_drop <= n_drop; r_med <= n_med;
    end

    always_comb begin
        n_state = r_state; n_size = r_size; n_v = r_v; n_t = r_t; n_mv = r_mv;
        n_i = r_i; n_ph = r_ph; n_second = r_second; n_drop = r_drop;
        n_ov = r_ov; n_med = r_med;
        o_we = 2'b00; o_waddr = '0; o_wdata = r_v;
        o_raddr_a = '0; o_raddr_b = '0;
        tot = r_size[0] + r_size[1];
        lc = {r_i[AW-1:0], 1'b1};
        rc = lc + ONE;
        best_v = r_mv; best_i = r_i;
        if (o_valid && i_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_v = $signed(i_sample);
                    n_drop = ({1'b0, tot} >= (AW+2)'(CAPACITY));
                    n_state = n_drop ? S_DONE : S_TOPS;
                end
            end
            S_TOPS: n_state = S_DECIDE;   // tops read at address 0
            S_DECIDE: begin
                n_second = 1'b0;
                n_state  = S_PUSH_RD;
                if (r_size[0] == r_size[1]) begin
                    n_ph = !(r_size[0] == '0 || r_v < top_l);
                end else if (r_size[0] > r_size[1]) begin
                    if (r_v >= top_l) n_ph = 1'b1;
                    else begin
                        n_ph = 1'b0; n_t = top_l; n_second = 1'b1; n_state = S_POP_LAST;
                    end
                end else begin
                    if (r_v <= top_u) n_ph = 1'b0;
                    else begin
                        n_ph = 1'b1; n_t = top_u; n_second = 1'b1; n_state = S_POP_LAST;
                    end
                end
                if (n_state == S_PUSH_RD) begin
                    n_i = r_size[n_ph];
                    n_size[n_ph] = r_size[n_ph] + ONE;
                end
            end
            S_POP_LAST: begin
                // fetch the last entry; it becomes the sifting value
                o_raddr_a = AW'(r_size[r_ph] - ONE);
                n_size[r_ph] = r_size[r_ph] - ONE;
                n_i = '0;
                n_state = S_POP_RD;
            end
            S_POP_RD: begin
                n_state = S_POP_CMP;
                o_raddr_a = AW'(lc);
                o_raddr_b = AW'(rc);
                n_mv = ra;
            end
            S_POP_CMP: begin
                if (lc < r_size[r_ph] && above(r_ph == 1'b0, ra, best_v)) begin
                    best_v = ra; best_i = lc;
                end
                if (rc < r_size[r_ph] && above(r_ph == 1'b0, rb, best_v)) begin
                    best_v = rb; best_i = rc;
                end
                o_we[r_ph] = 1'b1;
                o_waddr = AW'(r_i);
                if (best_i == r_i) begin
                    o_wdata = r_mv;
                    n_i = r_size[r_ph];
                    n_size[r_ph] = r_size[r_ph] + ONE;
                    n_state = S_PUSH_RD;
                end else begin
                    o_wdata = best_v;
                    n_i = best_i;
                    o_raddr_a = AW'({best_i[AW-1:0], 1'b1});
                    o_raddr_b = AW'({best_i[AW-1:0], 1'b1} + ONE);
                    n_state = S_POP_CMP;
                end
            end
            S_PUSH_RD: begin
                o_raddr_a = AW'((r_i - ONE) >> 1);
                n_state = S_PUSH_CMP;
            end
            S_PUSH_CMP: begin
                o_we[r_ph] = 1'b1;
                o_waddr = AW'(r_i);
                if (r_i != '0 && above(r_ph == 1'b0, r_v, ra)) begin
                    o_wdata = ra;
                    n_i = (r_i - ONE) >> 1;
                    o_raddr_a = AW'((n_i - ONE) >> 1);
                    n_state = S_PUSH_CMP;
                end else begin
                    o_wdata = r_v;
                    if (r_second) begin
                        n_second = 1'b0;
                        n_v = r_t;
                        n_ph = !r_ph;
                        n_i = r_size[!r_ph];
                        n_size[!r_ph] = r_size[!r_ph] + ONE;
                        n_state = S_PUSH_RD;
                    end else begin
                        n_state = S_TOPS;
                        n_second = 1'b0;  // reread the tops after this write
                        n_drop = 1'b0;
                    end
                end
                if (n_state == S_TOPS) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_second || r_drop) begin
                    o_raddr_a = '0;
                    n_second = 1'b1;
                    n_drop = r_drop;
                end else begin
                    o_raddr_a = '0;
                    if (r_size[0] == '0 && r_size[1] == '0) n_med = '0;
                    else if (r_size[0] == r_size[1])
                        n_med = {top_l[SAMPLE_BITS-1], top_l} + {top_u[SAMPLE_BITS-1], top_u};
                    else if (r_size[0] > r_size[1]) n_med = {top_l, 1'b0};
                    else n_med = {top_u, 1'b0};
                    n_ov = 1'b1;
                    n_second = 1'b0;
                    n_state = S_IDLE;
                end
                if (r_drop && r_second) begin
                    if (r_size[0] == '0 && r_size[1] == '0) n_med = '0;
                    else if (r_size[0] == r_size[1])
                        n_med = {top_l[SAMPLE_BITS-1], top_l} + {top_u[SAMPLE_BITS-1], top_u};
                    else if (r_size[0] > r_size[1]) n_med = {top_l, 1'b0};
                    else n_med = {top_u, 1'b0};
                    n_ov = 1'b1;
                    n_second = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/running_median_two_heaps_top.sv @@
// ---------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median of a sample stream kept in a max-heap and a min-heap.
// ---------------------------------------------------------------------------
// One sample is taken at a time. The result word appears once the sample
// has been placed: each sift moves through the heap levels one at a time,
// and when a heap top is displaced a pop sift-down and a second push
// follow; every sift step is one read-modify-write of a heap memory.
// A dropped sample leaves the heaps untouched.
// The next sample can be taken in the cycle after the result word is accepted.
module running_median_two_heaps_top
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS:0]   o_median_twice,
    output logic [$clog2(CAPACITY+1)-1:0] o_stored_count,
    output logic                   o_dropped
);

    localparam int DEPTH = CAPACITY / 2 + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [1:0]             we;
    logic [AW-1:0]          waddr, raddr_a, raddr_b;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [SAMPLE_BITS-1:0] rdata_a [2];
    logic [SAMPLE_BITS-1:0] rdata_b [2];

    for (genvar g = 0; g < 2; g++) begin : g_heap
        rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram (
            .i_clk(i_clk), .i_we(we[g]), .i_waddr(waddr), .i_wdata(wdata),
            .i_raddr_a(raddr_a), .i_raddr_b(raddr_b),
            .o_rdata_a(rdata_a[g]), .o_rdata_b(rdata_b[g])
        );
    end

    rmth_ctrl #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_median_twice(o_median_twice), .o_stored_count(o_stored_count),
        .o_dropped(o_dropped),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_raddr_a(raddr_a), .o_raddr_b(raddr_b),
        .i_rdata_a(rdata_a), .i_rdata_b(rdata_b)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stored_count <= CAPACITY) else $error("count above capacity");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_stored_count == CAPACITY))
        else $error("drop with free space");
`endif

endmodule

@@ verif/running_median_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_median_checker
// Watches the sample and result channels of the two-heap running median,
// keeps its own two heaps, and compares every result word field by field.
// ---------------------------------------------------------------------------
module running_median_checker #(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32,
    parameter int CNT_BITS    = $clog2(CAPACITY+1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [SAMPLE_BITS:0]   i_median_twice,
    input  logic [CNT_BITS-1:0]    i_stored_count,
    input  logic                   i_dropped,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int HALF = CAPACITY / 2 + 1;

    typedef struct packed {
        logic [SAMPLE_BITS:0]  median_twice;
        logic [CNT_BITS-1:0]   stored_count;
        logic                  dropped;
    } t_median_word;

    longint lo_heap[HALF];
    longint hi_heap[HALF];
    int     lo_n;
    int     hi_n;
    t_median_word median_q[$];

    function automatic bit ranks_above(bit is_max, longint a, longint b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_add(ref longint h[HALF], ref int n, input bit is_max,
                            input longint v);
        int i;
        int p;
        longint t;
        i = n;
        if (i >= HALF) return;
        h[i] = v;
        n = i + 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_above(is_max, h[i], h[p])) break;
            t = h[i]; h[i] = h[p]; h[p] = t;
            i = p;
        end
    endtask

    task automatic heap_take(ref longint h[HALF], ref int n, input bit is_max,
                             output longint top);
        int i;
        int l;
        int best;
        longint t;
        top = 0;
        if (n == 0) return;
        top = h[0];
        n--;
        h[0] = h[n];
        i = 0;
        forever begin
            l = 2 * i + 1;
            best = i;
            if (l < n && ranks_above(is_max, h[l], h[best])) best = l;
            if (l + 1 < n && ranks_above(is_max, h[l+1], h[best])) best = l + 1;
            if (best == i) break;
            t = h[i]; h[i] = h[best]; h[best] = t;
            i = best;
        end
    endtask

    task automatic place_sample(input longint v);
        longint t;
        if (lo_n == hi_n) begin
            if (lo_n == 0 || v < lo_heap[0]) heap_add(lo_heap, lo_n, 1, v);
            else heap_add(hi_heap, hi_n, 0, v);
        end else if (lo_n > hi_n) begin
            if (v >= lo_heap[0]) begin
                heap_add(hi_heap, hi_n, 0, v);
            end else begin
                heap_take(lo_heap, lo_n, 1, t);
                heap_add(lo_heap, lo_n, 1, v);
                heap_add(hi_heap, hi_n, 0, t);
            end
        end else begin
            if (v <= hi_heap[0]) begin
                heap_add(lo_heap, lo_n, 1, v);
            end else begin
                heap_take(hi_heap, hi_n, 0, t);
                heap_add(hi_heap, hi_n, 0, v);
                heap_add(lo_heap, lo_n, 1, t);
            end
        end
    endtask

    task automatic predict_median(input logic [SAMPLE_BITS-1:0] raw);
        t_median_word w;
        longint m;
        w.dropped = (lo_n + hi_n >= CAPACITY);
        if (!w.dropped) place_sample(longint'($signed(raw)));
        if (lo_n == 0 && hi_n == 0) m = 0;
        else if (lo_n == hi_n) m = lo_heap[0] + hi_heap[0];
        else if (lo_n > hi_n) m = 2 * lo_heap[0];
        else m = 2 * hi_heap[0];
        w.median_twice = m[SAMPLE_BITS:0];
        w.stored_count = CNT_BITS'(lo_n + hi_n);
        median_q = {median_q, w};
    endtask

    always @(posedge i_clk) begin
        t_median_word want;
        if (!i_rst_n) begin
            lo_n = 0;
            hi_n = 0;
            o_fail_count = 0;
            median_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_median(i_sample);
            if (i_out_valid && i_out_ready) begin
                if (median_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word: median_twice=%0h count=%0d",
                                 i_median_twice, i_stored_count);
                end else begin
                    want = median_q.pop_front();
                    if (want.median_twice !== i_median_twice ||
                        want.stored_count !== i_stored_count ||
                        want.dropped !== i_dropped) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch: exp median_twice=%0h count=%0d drop=%0b,",
                                      " got %0h %0d %0b"},
                                     want.median_twice, want.stored_count, want.dropped,
                                     i_median_twice, i_stored_count, i_dropped);
                    end
                end
            end
        end
        o_pending = median_q.size();
    end

endmodule

@@ verif/running_median_two_heaps_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_median_two_heaps_top_tb
// Drives samples with random gaps and result stalls, fills the store past
// capacity, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module running_median_two_heaps_top_tb
    import rmth_pkg::*;
;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int CNT_BITS    = $clog2(CAPACITY+1);
    localparam int N_RANDOM    = 1100;
    localparam int STALL_LIMIT = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_valid;
    logic                   i_ready;
    logic [SAMPLE_BITS:0]   o_median_twice;
    logic [CNT_BITS-1:0]    o_stored_count;
    logic                   o_dropped;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles;
    bit                     stim_done;

    running_median_two_heaps_top #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

    running_median_checker #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_sample(i_sample),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_median_twice(o_median_twice), .i_stored_count(o_stored_count),
        .i_dropped(o_dropped), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Send one word, after a random gap; hold valid and payload until taken.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'($urandom_range(0, 7)) - SAMPLE_BITS'(4);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_sample <= '0;
        stim_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes, ties and sign boundaries
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        send_sample('0);
        send_sample('0);
        send_sample('1);
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(32'h0001_0000));
        send_sample(SAMPLE_BITS'(32'hffff_0000));
        send_sample(SAMPLE_BITS'(32'h5555_5555));
        send_sample(SAMPLE_BITS'(32'haaaa_aaaa));
        for (int k = 0; k < N_RANDOM; k++) send_sample(pick_sample());
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: stall a random number of cycles before each word.
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (stim_done && pending == 0) begin
                repeat (60) @(posedge i_clk);
                if (fail_count == 0 && pending == 0) $display("status: pass");
                else $display("status: fail");
                $finish;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
